// ===== src/ttps_pkg.sv =====
package ttps_pkg;

    // Table geometry defaults
    localparam int DEF_INDEX_BITS = 16;
    localparam int DEF_MOVE_BITS  = 32;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int PLY_W   = 8;
    localparam int MOVE_W  = 32;
    localparam int BOUND_W = 2;
    localparam int SDEPTH_W = 7;

    // Input tdata layout, lowest bit first
    localparam int S_KEY_LSB   = 0;
    localparam int S_DEPTH_LSB = S_KEY_LSB + KEY_W;
    localparam int S_ALPHA_LSB = S_DEPTH_LSB + DEPTH_W;
    localparam int S_BETA_LSB  = S_ALPHA_LSB + SCORE_W;
    localparam int S_PLY_LSB   = S_BETA_LSB + SCORE_W;
    localparam int S_SCORE_LSB = S_PLY_LSB + PLY_W;
    localparam int S_MOVE_LSB  = S_SCORE_LSB + SCORE_W;
    localparam int S_BOUND_LSB = S_MOVE_LSB + MOVE_W;
    localparam int S_USED_W    = S_BOUND_LSB + BOUND_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int M_HIT_BIT     = 0;
    localparam int M_CUTOFF_BIT  = 1;
    localparam int M_MOVE_LSB    = 2;
    localparam int M_SCORE_LSB   = M_MOVE_LSB + MOVE_W;
    localparam int M_WRITTEN_BIT = M_SCORE_LSB + SCORE_W;
    localparam int M_USED_W      = M_WRITTEN_BIT + 1;
    localparam int M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;

    // Score and depth limits
    localparam int MATE_EDGE   = 29000;
    localparam int SCORE_LIMIT = 32000;
    localparam int DEPTH_CAP   = 127;

    // Command codes (s_tuser)
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // Bound codes
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

endpackage

// ===== src/transposition_table_probe_store_unit.sv =====
// Transposition table, direct mapped, depth preferred replacement.
// Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) carries one command per beat:
// s_tuser selects probe or store, s_tdata carries key, depth, window, ply, score,
// move and bound. Master channel (m_tvalid/m_tready/m_tdata) returns exactly one
// result beat per command: hit, cutoff, move and score for a probe, written for
// a store.
// The table sits in one synchronous single-port-style memory of 2^INDEX_BITS slots
// with a registered read. Each command reads its slot in the accept cycle and
// writes it back in the write-back state once the output register is free, and
// the result goes to the master side as the write-back completes. s_tready is low
// during write-back, so a new beat is taken only after the last one is written back;
// the write always lands before the next read, so no forwarding is needed.
// After aresetn is released the block sweeps the memory to zero, one slot per
// cycle, through all 2^INDEX_BITS slots; s_tready stays low until the sweep is done.
// A result that waits on a stalled receiver sits in the output register while the
// next beat is accepted and read; that beat holds in its write-back cycle until
// the output register frees up.
module transposition_table_probe_store_unit
    import ttps_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int MOVE_BITS  = DEF_MOVE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key[63:0], depth[71:64], alpha[87:72], beta[103:88], ply[111:104],
    // score[127:112], move[159:128], bound[161:160], zero fill to 168
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit[0], cutoff[1], move_out[33:2], score_out[49:34], written[50],
    // zero fill to 56
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOTS = 1 << INDEX_BITS;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [MOVE_BITS-1:0] move;
        logic [SDEPTH_W-1:0]  depth;
        logic [BOUND_W-1:0]   bound;
        logic [SCORE_W-1:0]   score;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Slot memory and its registered read port
    entry_t entries_mem [SLOTS];
    entry_t rdata_reg;
    logic   mem_re;
    logic   mem_we;
    logic [INDEX_BITS-1:0] wr_idx;
    entry_t wdata;

    state_t state_reg;
    logic [INDEX_BITS-1:0] clr_idx_reg;

    // Command held for its write-back cycle
    logic                      cmd_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [DEPTH_W-1:0]        depth_reg;
    logic signed [SCORE_W-1:0] alpha_reg;
    logic signed [SCORE_W-1:0] beta_reg;
    logic [PLY_W-1:0]          ply_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [MOVE_BITS-1:0]      move_reg;
    logic [BOUND_W-1:0]        bound_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic s_accept;
    logic out_free;

    // Probe path
    logic                    key_match;
    logic signed [16:0]      ply_s;
    logic signed [16:0]      stored_s;
    logic signed [16:0]      probe_s;
    logic                    depth_ok;
    logic                    bound_ok;
    logic                    cut;

    // Store path
    logic [SDEPTH_W-1:0]     st_depth;
    logic signed [17:0]      st_adj;
    logic signed [SCORE_W-1:0] st_score;
    logic                    replace;

    logic [M_TDATA_W-1:0]    result_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign mem_re   = s_accept;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Probe: match key, pull mate scores toward zero by ply, test the depth and the bound
    always_comb begin
        key_match = (rdata_reg.key == key_reg);
        ply_s     = $signed({9'd0, ply_reg});
        stored_s  = 17'($signed(rdata_reg.score));
        if (stored_s > 17'(MATE_EDGE)) begin
            probe_s = stored_s - ply_s;
        end else if (stored_s < -17'(MATE_EDGE)) begin
            probe_s = stored_s + ply_s;
        end else begin
            probe_s = stored_s;
        end
        depth_ok = ({1'b0, rdata_reg.depth} >= depth_reg);
        case (rdata_reg.bound)
            BOUND_EXACT: bound_ok = 1'b1;
            BOUND_LOWER: bound_ok = (probe_s >= 17'(beta_reg));
            BOUND_UPPER: bound_ok = (probe_s <= 17'(alpha_reg));
            default:     bound_ok = 1'b0;
        endcase
        cut = depth_ok && bound_ok;
    end

    // Store: saturate depth, push mate scores away from zero, clamp, decide replacement
    always_comb begin
        st_depth = (depth_reg > DEPTH_W'(DEPTH_CAP)) ? SDEPTH_W'(DEPTH_CAP)
                                                    : depth_reg[SDEPTH_W-1:0];
        st_adj = 18'(score_reg);
        if (score_reg > 16'(MATE_EDGE)) begin
            st_adj = 18'(score_reg) + $signed({10'd0, ply_reg});
        end else if (score_reg < -16'(MATE_EDGE)) begin
            st_adj = 18'(score_reg) - $signed({10'd0, ply_reg});
        end
        if (st_adj > 18'(SCORE_LIMIT)) begin
            st_score = 16'(SCORE_LIMIT);
        end else if (st_adj < -18'(SCORE_LIMIT)) begin
            st_score = -16'(SCORE_LIMIT);
        end else begin
            st_score = st_adj[SCORE_W-1:0];
        end
        replace = (rdata_reg.depth <= st_depth) || !key_match;
    end

    // Result beat and memory write port
    always_comb begin
        result_next = '0;
        mem_we      = 1'b0;
        wr_idx      = clr_idx_reg;
        wdata       = '0;
        if (cmd_reg == CMD_PROBE) begin
            if (key_match) begin
                result_next[M_HIT_BIT]    = 1'b1;
                result_next[M_CUTOFF_BIT] = cut;
                result_next[M_SCORE_LSB +: SCORE_W] = probe_s[SCORE_W-1:0];
                result_next[M_MOVE_LSB +: MOVE_W]   = MOVE_W'(rdata_reg.move);
            end
        end else begin
            result_next[M_WRITTEN_BIT] = replace;
        end
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_LOOKUP: begin
                wr_idx = key_reg[INDEX_BITS-1:0];
                wdata  = '{key: key_reg, move: move_reg, depth: st_depth,
                           bound: bound_reg, score: st_score};
                mem_we = out_free && (cmd_reg == CMD_STORE) && replace;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entries_mem[wr_idx] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= entries_mem[s_tdata[S_KEY_LSB +: INDEX_BITS]];
        end
    end

    // Capture the command fields on acceptance
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[S_KEY_LSB +: KEY_W];
            depth_reg <= s_tdata[S_DEPTH_LSB +: DEPTH_W];
            alpha_reg <= s_tdata[S_ALPHA_LSB +: SCORE_W];
            beta_reg  <= s_tdata[S_BETA_LSB +: SCORE_W];
            ply_reg   <= s_tdata[S_PLY_LSB +: PLY_W];
            score_reg <= s_tdata[S_SCORE_LSB +: SCORE_W];
            move_reg  <= s_tdata[S_MOVE_LSB +: MOVE_BITS];
            bound_reg <= s_tdata[S_BOUND_LSB +: BOUND_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop the beat once taken, unless a new one replaces it
            if (m_tready && !((state_reg == ST_LOOKUP) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
                    if (&clr_idx_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    // Hold here until the output register frees up
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted beat did not move to write-back");

    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_LOOKUP))
        else $error("result beat raised outside write-back");

    a_cutoff_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_CUTOFF_BIT]) |-> m_tdata[M_HIT_BIT])
        else $error("cutoff reported without a hit");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("slot memory written while idle");

    a_clear_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> !$past(s_accept))
        else $error("beat accepted during clearing sweep");
`endif

endmodule
